>>> hw/rtl/encadc_pkg.sv
package encadc_pkg;

  localparam int WINDOW_DEPTH_DEF = 16;
  localparam int ANGLE_BITS_DEF   = 14;
  localparam int SAMPLE_BITS_DEF  = 12;
  localparam int TURN_BITS_DEF    = 16;

  localparam int POS_BITS       = 32;
  localparam int TURNS_OUT_BITS = 16;
  localparam int VEL_BITS       = 32;
  localparam int STEP_BITS      = 16;
  localparam int GAIN_BITS      = 17;
  localparam int GAIN_FRAC      = 16;
  localparam int OFFSET_BITS    = 30;
  localparam int CUR_OFS_BITS   = 13;
  localparam int SUM_BITS       = 16;
  localparam int AVG_BITS       = 14;
  localparam int BUS_AVG_BITS   = 12;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  localparam int NUM_CH = 4;
  localparam int CH_A   = 0;
  localparam int CH_B   = 1;
  localparam int CH_C   = 2;
  localparam int CH_BUS = 3;

  localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1 << GAIN_FRAC);
  localparam logic signed [STEP_BITS-1:0] STEP_LIMIT = 16'sd32767;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FAST_GAIN  = 3'd0,
    REG_SLOW_GAIN  = 3'd1,
    REG_POS_OFFSET = 3'd2,
    REG_A_OFFSET   = 3'd3,
    REG_B_OFFSET   = 3'd4,
    REG_C_OFFSET   = 3'd5
  } cfg_reg_t;

  typedef logic [SUM_BITS-1:0] sum_t;

  typedef struct packed {
    logic [GAIN_BITS-1:0]           fast_gain;
    logic [GAIN_BITS-1:0]           slow_gain;
    logic signed [OFFSET_BITS-1:0]  pos_zero;
    logic signed [CUR_OFS_BITS-1:0] phase_a_offset;
    logic signed [CUR_OFS_BITS-1:0] phase_b_offset;
    logic signed [CUR_OFS_BITS-1:0] phase_c_offset;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic adv1;
    logic adv2;
    logic adv3;
  } pipe_ctl_t;

endpackage

>>> hw/rtl/encadc_cfg.sv
module encadc_cfg (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [encadc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [encadc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output encadc_pkg::cfg_t                       cfg
);

  encadc_pkg::cfg_t cfg_r;

  function automatic logic [encadc_pkg::GAIN_BITS-1:0] sat_gain(
    input logic [encadc_pkg::CFG_DATA_BITS-1:0] d
  );
    logic [encadc_pkg::GAIN_BITS-1:0] g;
    g = d[encadc_pkg::GAIN_BITS-1:0];
    return (g > encadc_pkg::GAIN_ONE) ? encadc_pkg::GAIN_ONE : g;
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        encadc_pkg::REG_FAST_GAIN:  cfg_r.fast_gain <= sat_gain(cfg_data);
        encadc_pkg::REG_SLOW_GAIN:  cfg_r.slow_gain <= sat_gain(cfg_data);
        encadc_pkg::REG_POS_OFFSET:
          cfg_r.pos_zero <= cfg_data[encadc_pkg::OFFSET_BITS-1:0];
        encadc_pkg::REG_A_OFFSET:
          cfg_r.phase_a_offset <= cfg_data[encadc_pkg::CUR_OFS_BITS-1:0];
        encadc_pkg::REG_B_OFFSET:
          cfg_r.phase_b_offset <= cfg_data[encadc_pkg::CUR_OFS_BITS-1:0];
        encadc_pkg::REG_C_OFFSET:
          cfg_r.phase_c_offset <= cfg_data[encadc_pkg::CUR_OFS_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/encadc_window.sv
module encadc_window #(
  parameter int WINDOW_DEPTH = encadc_pkg::WINDOW_DEPTH_DEF,
  parameter int SAMPLE_BITS  = encadc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  encadc_pkg::pipe_ctl_t                           ctl,
  input  logic [encadc_pkg::NUM_CH-1:0][SAMPLE_BITS-1:0]  samples,
  output encadc_pkg::sum_t [encadc_pkg::NUM_CH-1:0]       quot
);

  localparam int SLOT_BITS = $clog2(WINDOW_DEPTH);
  localparam int SHIFT     = encadc_pkg::SUM_BITS + SLOT_BITS;
  localparam int PROD_BITS = 2 * encadc_pkg::SUM_BITS + 1;
  // exact reciprocal for any 16-bit dividend
  localparam logic [encadc_pkg::SUM_BITS:0] RECIP =
    (encadc_pkg::SUM_BITS + 1)'((2**SHIFT + WINDOW_DEPTH - 1) / WINDOW_DEPTH);

  typedef logic [encadc_pkg::NUM_CH-1:0][SAMPLE_BITS-1:0] entry_t;

  entry_t mem [WINDOW_DEPTH];

  logic [WINDOW_DEPTH-1:0] vld_r;
  logic [SLOT_BITS-1:0]    slot_r, slot_nxt, wr_slot_r;
  logic                    rd_vld_r;
  entry_t                  rd_q_r, samp1_r, old_w;
  logic                    drop_old;
  encadc_pkg::sum_t [encadc_pkg::NUM_CH-1:0] sums_r, sums_nxt, sum2_r, quot_r;
  logic [PROD_BITS-1:0]    prod [encadc_pkg::NUM_CH];

  assign quot = quot_r;

  always_comb begin
    slot_nxt = (slot_r == SLOT_BITS'(WINDOW_DEPTH - 1)) ? '0 : slot_r + 1'b1;
    old_w    = rd_vld_r ? rd_q_r : '0;
    // a slot whose stored bus count is zero does not leave the sums
    drop_old = (old_w[encadc_pkg::CH_BUS] != '0);
    for (int k = 0; k < encadc_pkg::NUM_CH; k++) begin
      sums_nxt[k] = sums_r[k] + encadc_pkg::SUM_BITS'(samp1_r[k])
                  - (drop_old ? encadc_pkg::SUM_BITS'(old_w[k]) : '0);
      prod[k] = PROD_BITS'(sum2_r[k]) * PROD_BITS'(RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      rd_q_r    <= mem[slot_r];
      samp1_r   <= samples;
      wr_slot_r <= slot_r;
    end
    if (ctl.adv1) begin
      mem[wr_slot_r] <= samp1_r;
      sum2_r         <= sums_nxt;
    end
    if (ctl.adv2) begin
      for (int k = 0; k < encadc_pkg::NUM_CH; k++) begin
        quot_r[k] <= encadc_pkg::SUM_BITS'(prod[k] >> SHIFT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      slot_r   <= '0;
      rd_vld_r <= 1'b0;
      sums_r   <= '0;
    end else begin
      if (ctl.accept) begin
        rd_vld_r <= vld_r[slot_r];
        slot_r   <= slot_nxt;
      end
      if (ctl.adv1) begin
        vld_r[wr_slot_r] <= 1'b1;
        sums_r           <= sums_nxt;
      end
    end
  end

endmodule

>>> hw/rtl/encadc_motion.sv
module encadc_motion #(
  parameter int ANGLE_BITS = encadc_pkg::ANGLE_BITS_DEF,
  parameter int TURN_BITS  = encadc_pkg::TURN_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  encadc_pkg::pipe_ctl_t                       ctl,
  input  encadc_pkg::cfg_t                            cfg,
  input  logic [ANGLE_BITS-1:0]                       angle,
  output logic [encadc_pkg::POS_BITS-1:0]             pos3,
  output logic [encadc_pkg::TURNS_OUT_BITS-1:0]       turns3,
  output logic signed [encadc_pkg::VEL_BITS-1:0]      fast_vel_nxt,
  output logic signed [encadc_pkg::VEL_BITS-1:0]      slow_vel_nxt
);

  localparam int GSTEP_BITS = encadc_pkg::GAIN_BITS + 1 + encadc_pkg::STEP_BITS;
  localparam int GV_BITS    = encadc_pkg::GAIN_BITS + 1 + encadc_pkg::VEL_BITS;
  localparam int VB         = encadc_pkg::VEL_BITS;
  localparam int GF         = encadc_pkg::GAIN_FRAC;
  localparam logic signed [ANGLE_BITS:0] HALF_TURN =
    (ANGLE_BITS + 1)'(2**(ANGLE_BITS - 1));

  logic [TURN_BITS-1:0]                   turn_r, turn_nxt;
  logic [ANGLE_BITS-1:0]                  prev_angle_r;
  logic signed [ANGLE_BITS:0]             angle_diff;
  logic [encadc_pkg::POS_BITS-1:0]        pos_w, pos1_r, pos2_r, pos3_r, prev_pos_r;
  logic [encadc_pkg::TURNS_OUT_BITS-1:0]  turns_w, turns1_r, turns2_r, turns3_r;
  logic signed [encadc_pkg::POS_BITS-1:0] step_raw;
  logic signed [encadc_pkg::STEP_BITS-1:0] step_sat, step2_r;
  logic signed [GSTEP_BITS-1:0]           gstep_fast, gstep_slow;
  logic [VB-1:0]                          gstep_fast3_r, gstep_slow3_r;
  logic signed [VB-1:0]                   fast_v_r, slow_v_r;
  logic signed [GV_BITS-1:0]              fast_gv, slow_gv, fast_neg, slow_neg;

  function automatic logic signed [encadc_pkg::POS_BITS-1:0] STEP_LIMIT_W();
    return encadc_pkg::POS_BITS'(encadc_pkg::STEP_LIMIT);
  endfunction

  assign pos3   = pos3_r;
  assign turns3 = turns3_r;

  always_comb begin
    angle_diff = $signed({1'b0, angle}) - $signed({1'b0, prev_angle_r});
    if (angle_diff < -HALF_TURN) begin
      turn_nxt = turn_r + 1'b1;
    end else if (angle_diff > HALF_TURN) begin
      turn_nxt = turn_r - 1'b1;
    end else begin
      turn_nxt = turn_r;
    end
    pos_w = (encadc_pkg::POS_BITS'($signed(turn_nxt)) << ANGLE_BITS)
          + encadc_pkg::POS_BITS'(angle)
          - encadc_pkg::POS_BITS'(cfg.pos_zero);
    turns_w = encadc_pkg::TURNS_OUT_BITS'(32'(turn_nxt));

    step_raw = $signed(pos1_r - prev_pos_r);
    if (step_raw > STEP_LIMIT_W()) begin
      step_sat = encadc_pkg::STEP_LIMIT;
    end else if (step_raw < -STEP_LIMIT_W()) begin
      step_sat = -encadc_pkg::STEP_LIMIT;
    end else begin
      step_sat = encadc_pkg::STEP_BITS'(step_raw);
    end

    gstep_fast = $signed({1'b0, cfg.fast_gain}) * step2_r;
    gstep_slow = $signed({1'b0, cfg.slow_gain}) * step2_r;

    // v + g*step + floor(-g*v / 2^16), all modulo 2^32
    fast_gv  = $signed({1'b0, cfg.fast_gain}) * fast_v_r;
    slow_gv  = $signed({1'b0, cfg.slow_gain}) * slow_v_r;
    fast_neg = -fast_gv;
    slow_neg = -slow_gv;
    fast_vel_nxt = fast_v_r + $signed(gstep_fast3_r) + $signed(fast_neg[VB+GF-1:GF]);
    slow_vel_nxt = slow_v_r + $signed(gstep_slow3_r) + $signed(slow_neg[VB+GF-1:GF]);
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      pos1_r   <= pos_w;
      turns1_r <= turns_w;
    end
    if (ctl.adv1) begin
      step2_r  <= step_sat;
      pos2_r   <= pos1_r;
      turns2_r <= turns1_r;
    end
    if (ctl.adv2) begin
      gstep_fast3_r <= VB'(gstep_fast);
      gstep_slow3_r <= VB'(gstep_slow);
      pos3_r        <= pos2_r;
      turns3_r      <= turns2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_r       <= '0;
      prev_angle_r <= '0;
      prev_pos_r   <= '0;
      fast_v_r     <= '0;
      slow_v_r     <= '0;
    end else begin
      if (ctl.accept) begin
        turn_r       <= turn_nxt;
        prev_angle_r <= angle;
      end
      if (ctl.adv1) begin
        prev_pos_r <= pos1_r;
      end
      if (ctl.adv3) begin
        fast_v_r <= fast_vel_nxt;
        slow_v_r <= slow_vel_nxt;
      end
    end
  end

endmodule

>>> hw/rtl/encoder_adc_state_estimator_core.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready   | angle, phase a/b/c and bus samples
// out     | output    | out_valid / out_ready | position, turns, velocities, averages
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// One transaction per cycle while out_ready is high; the stage registers feed the output.
// The window RAM read issued at accept and its write-back one stage later set the pipeline.
// Reset clears turns, angle, position, filters, window sums and window slot valid bits.
// A stalled output holds its register; upstream stages keep filling until all are full.
module encoder_adc_state_estimator_core #(
  parameter int WINDOW_DEPTH = encadc_pkg::WINDOW_DEPTH_DEF,
  parameter int ANGLE_BITS   = encadc_pkg::ANGLE_BITS_DEF,
  parameter int SAMPLE_BITS  = encadc_pkg::SAMPLE_BITS_DEF,
  parameter int TURN_BITS    = encadc_pkg::TURN_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,

  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [ANGLE_BITS-1:0]                       in_angle,
  input  logic [SAMPLE_BITS-1:0]                      in_phase_a_sample,
  input  logic [SAMPLE_BITS-1:0]                      in_phase_b_sample,
  input  logic [SAMPLE_BITS-1:0]                      in_phase_c_sample,
  input  logic [SAMPLE_BITS-1:0]                      in_bus_sample,

  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic signed [encadc_pkg::POS_BITS-1:0]      out_position,
  output logic signed [encadc_pkg::TURNS_OUT_BITS-1:0] out_turns,
  output logic signed [encadc_pkg::VEL_BITS-1:0]      out_fast_velocity,
  output logic signed [encadc_pkg::VEL_BITS-1:0]      out_slow_velocity,
  output logic signed [encadc_pkg::AVG_BITS-1:0]      out_phase_a_average,
  output logic signed [encadc_pkg::AVG_BITS-1:0]      out_phase_b_average,
  output logic signed [encadc_pkg::AVG_BITS-1:0]      out_phase_c_average,
  output logic [encadc_pkg::BUS_AVG_BITS-1:0]         out_bus_average,

  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [encadc_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
  input  logic [encadc_pkg::CFG_DATA_BITS-1:0]        cfg_data
);

  encadc_pkg::cfg_t      cfg;
  encadc_pkg::pipe_ctl_t ctl;

  logic v1_r, v2_r, v3_r, out_valid_r;
  logic load_out, free3, free2, free1;

  logic [encadc_pkg::NUM_CH-1:0][SAMPLE_BITS-1:0]  samples;
  encadc_pkg::sum_t [encadc_pkg::NUM_CH-1:0]       quot;
  logic [encadc_pkg::POS_BITS-1:0]                 pos3;
  logic [encadc_pkg::TURNS_OUT_BITS-1:0]           turns3;
  logic signed [encadc_pkg::VEL_BITS-1:0]          fast_vel_nxt, slow_vel_nxt;

  logic [encadc_pkg::POS_BITS-1:0]       out_position_r;
  logic [encadc_pkg::TURNS_OUT_BITS-1:0] out_turns_r;
  logic [encadc_pkg::VEL_BITS-1:0]       out_fast_velocity_r, out_slow_velocity_r;
  logic [encadc_pkg::AVG_BITS-1:0]       out_a_avg_r, out_b_avg_r, out_c_avg_r;
  logic [encadc_pkg::AVG_BITS-1:0]       a_avg_nxt, b_avg_nxt, c_avg_nxt;
  logic [encadc_pkg::BUS_AVG_BITS-1:0]   out_bus_avg_r;

  // each stage advances when the one after it is empty or moving
  always_comb begin
    load_out   = !out_valid_r || out_ready;
    ctl.adv3   = v3_r && load_out;
    free3      = !v3_r || load_out;
    ctl.adv2   = v2_r && free3;
    free2      = !v2_r || free3;
    ctl.adv1   = v1_r && free2;
    free1      = !v1_r || free2;
    ctl.accept = in_valid && free1;
  end

  assign in_ready = free1;

  assign samples[encadc_pkg::CH_A]   = in_phase_a_sample;
  assign samples[encadc_pkg::CH_B]   = in_phase_b_sample;
  assign samples[encadc_pkg::CH_C]   = in_phase_c_sample;
  assign samples[encadc_pkg::CH_BUS] = in_bus_sample;

  encadc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  encadc_motion #(
    .ANGLE_BITS (ANGLE_BITS),
    .TURN_BITS  (TURN_BITS)
  ) u_motion (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .cfg          (cfg),
    .angle        (in_angle),
    .pos3         (pos3),
    .turns3       (turns3),
    .fast_vel_nxt (fast_vel_nxt),
    .slow_vel_nxt (slow_vel_nxt)
  );

  encadc_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .samples (samples),
    .quot    (quot)
  );

  always_comb begin
    a_avg_nxt = encadc_pkg::AVG_BITS'(quot[encadc_pkg::CH_A])
              - encadc_pkg::AVG_BITS'(cfg.phase_a_offset);
    b_avg_nxt = encadc_pkg::AVG_BITS'(quot[encadc_pkg::CH_B])
              - encadc_pkg::AVG_BITS'(cfg.phase_b_offset);
    c_avg_nxt = encadc_pkg::AVG_BITS'(quot[encadc_pkg::CH_C])
              - encadc_pkg::AVG_BITS'(cfg.phase_c_offset);
  end

  always_ff @(posedge clk) begin
    if (ctl.adv3) begin
      out_position_r      <= pos3;
      out_turns_r         <= turns3;
      out_fast_velocity_r <= fast_vel_nxt;
      out_slow_velocity_r <= slow_vel_nxt;
      out_a_avg_r         <= a_avg_nxt;
      out_b_avg_r         <= b_avg_nxt;
      out_c_avg_r         <= c_avg_nxt;
      out_bus_avg_r       <= encadc_pkg::BUS_AVG_BITS'(quot[encadc_pkg::CH_BUS]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= ctl.accept || (v1_r && !ctl.adv1);
      v2_r        <= ctl.adv1 || (v2_r && !ctl.adv2);
      v3_r        <= ctl.adv2 || (v3_r && !ctl.adv3);
      out_valid_r <= ctl.adv3 || (out_valid_r && !out_ready);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_position        = $signed(out_position_r);
  assign out_turns           = $signed(out_turns_r);
  assign out_fast_velocity   = $signed(out_fast_velocity_r);
  assign out_slow_velocity   = $signed(out_slow_velocity_r);
  assign out_phase_a_average = $signed(out_a_avg_r);
  assign out_phase_b_average = $signed(out_b_avg_r);
  assign out_phase_c_average = $signed(out_c_avg_r);
  assign out_bus_average     = out_bus_avg_r;

endmodule

>>> test/state_estimate_checker.sv
module state_estimate_checker
  import encadc_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [ANGLE_BITS_DEF-1:0]         in_angle,
  input  logic [SAMPLE_BITS_DEF-1:0]        in_phase_a_sample,
  input  logic [SAMPLE_BITS_DEF-1:0]        in_phase_b_sample,
  input  logic [SAMPLE_BITS_DEF-1:0]        in_phase_c_sample,
  input  logic [SAMPLE_BITS_DEF-1:0]        in_bus_sample,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [POS_BITS-1:0]        out_position,
  input  logic signed [TURNS_OUT_BITS-1:0]  out_turns,
  input  logic signed [VEL_BITS-1:0]        out_fast_velocity,
  input  logic signed [VEL_BITS-1:0]        out_slow_velocity,
  input  logic signed [AVG_BITS-1:0]        out_phase_a_average,
  input  logic signed [AVG_BITS-1:0]        out_phase_b_average,
  input  logic signed [AVG_BITS-1:0]        out_phase_c_average,
  input  logic [BUS_AVG_BITS-1:0]           out_bus_average,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]         cfg_index,
  input  logic [CFG_DATA_BITS-1:0]          cfg_data,
  output int                                pending,
  output int                                mismatches
);

  localparam int HALF_TURN = 1 << (ANGLE_BITS_DEF - 1);

  typedef logic [NUM_CH-1:0][SAMPLE_BITS_DEF-1:0] sample_set_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0]       position;
    logic signed [TURNS_OUT_BITS-1:0] turns;
    logic signed [VEL_BITS-1:0]       fast_velocity;
    logic signed [VEL_BITS-1:0]       slow_velocity;
    logic signed [AVG_BITS-1:0]       phase_a_average;
    logic signed [AVG_BITS-1:0]       phase_b_average;
    logic signed [AVG_BITS-1:0]       phase_c_average;
    logic [BUS_AVG_BITS-1:0]          bus_average;
  } estimate_t;

  cfg_t                        regs;
  logic [TURN_BITS_DEF-1:0]    turn_count;
  logic [ANGLE_BITS_DEF-1:0]   last_angle;
  logic [POS_BITS-1:0]         last_position;
  logic signed [VEL_BITS-1:0]  fast_vel;
  logic signed [VEL_BITS-1:0]  slow_vel;
  sample_set_t                 window [WINDOW_DEPTH_DEF];
  sum_t                        sums [NUM_CH];
  int                          slot;
  estimate_t                   expected_estimates [$];
  estimate_t                   want;
  int                          errors;

  function automatic logic signed [VEL_BITS-1:0] lowpass(
      input logic signed [VEL_BITS-1:0] vel, input logic [GAIN_BITS-1:0] gain,
      input int step);
    longint g;
    longint acc;
    g = (gain > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(gain);
    acc = g * (longint'(step) <<< GAIN_FRAC) + (longint'(GAIN_ONE) - g) * longint'(vel);
    return VEL_BITS'(acc >>> GAIN_FRAC);
  endfunction

  function automatic estimate_t estimate_next(input logic [ANGLE_BITS_DEF-1:0] angle,
                                              input sample_set_t samp);
    int adiff;
    int pos;
    int step;
    estimate_t e;
    adiff = int'(angle) - int'(last_angle);
    if (adiff < -HALF_TURN) begin
      turn_count = turn_count + 1'b1;
    end else if (adiff > HALF_TURN) begin
      turn_count = turn_count - 1'b1;
    end
    last_angle = angle;

    pos = (int'($signed(turn_count)) <<< ANGLE_BITS_DEF) + int'(angle)
          - int'(regs.pos_zero);
    step = pos - int'(last_position);
    if (step > int'(STEP_LIMIT)) step = int'(STEP_LIMIT);
    if (step < -int'(STEP_LIMIT)) step = -int'(STEP_LIMIT);
    last_position = pos;

    fast_vel = lowpass(fast_vel, regs.fast_gain, step);
    slow_vel = lowpass(slow_vel, regs.slow_gain, step);

    // subtract the old slot only when its stored bus count is nonzero
    if (window[slot][CH_BUS] != '0) begin
      for (int k = 0; k < NUM_CH; k++) sums[k] = sums[k] - sum_t'(window[slot][k]);
    end
    window[slot] = samp;
    for (int k = 0; k < NUM_CH; k++) sums[k] = sums[k] + sum_t'(samp[k]);
    slot = (slot + 1) % WINDOW_DEPTH_DEF;

    e.position        = pos;
    e.turns           = TURNS_OUT_BITS'(turn_count);
    e.fast_velocity   = fast_vel;
    e.slow_velocity   = slow_vel;
    e.phase_a_average = AVG_BITS'(int'(sums[CH_A] / WINDOW_DEPTH_DEF)
                                  - int'(regs.phase_a_offset));
    e.phase_b_average = AVG_BITS'(int'(sums[CH_B] / WINDOW_DEPTH_DEF)
                                  - int'(regs.phase_b_offset));
    e.phase_c_average = AVG_BITS'(int'(sums[CH_C] / WINDOW_DEPTH_DEF)
                                  - int'(regs.phase_c_offset));
    e.bus_average     = BUS_AVG_BITS'(sums[CH_BUS] / WINDOW_DEPTH_DEF);
    return e;
  endfunction

  task automatic compare_field(input string label, input logic signed [63:0] want_v,
                               input logic signed [63:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs          = '0;
      turn_count    = '0;
      last_angle    = '0;
      last_position = '0;
      fast_vel      = '0;
      slow_vel      = '0;
      foreach (window[i]) window[i] = '0;
      foreach (sums[k]) sums[k] = '0;
      slot          = 0;
      errors        = 0;
      expected_estimates.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FAST_GAIN:  regs.fast_gain      = cfg_data[GAIN_BITS-1:0];
          REG_SLOW_GAIN:  regs.slow_gain      = cfg_data[GAIN_BITS-1:0];
          REG_POS_OFFSET: regs.pos_zero       = cfg_data[OFFSET_BITS-1:0];
          REG_A_OFFSET:   regs.phase_a_offset = cfg_data[CUR_OFS_BITS-1:0];
          REG_B_OFFSET:   regs.phase_b_offset = cfg_data[CUR_OFS_BITS-1:0];
          REG_C_OFFSET:   regs.phase_c_offset = cfg_data[CUR_OFS_BITS-1:0];
          default: ;
        endcase
      end

      // check the output before queueing this edge's input
      if (out_valid && out_ready) begin
        if (expected_estimates.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, got position %0d",
                   $time, out_position);
          errors++;
        end else begin
          want = expected_estimates.pop_front();
          compare_field("position", want.position, out_position);
          compare_field("turns", want.turns, out_turns);
          compare_field("fast_velocity", want.fast_velocity, out_fast_velocity);
          compare_field("slow_velocity", want.slow_velocity, out_slow_velocity);
          compare_field("phase_a_average", want.phase_a_average, out_phase_a_average);
          compare_field("phase_b_average", want.phase_b_average, out_phase_b_average);
          compare_field("phase_c_average", want.phase_c_average, out_phase_c_average);
          compare_field("bus_average", want.bus_average, out_bus_average);
        end
      end

      if (in_valid && in_ready) begin
        expected_estimates.push_back(estimate_next(in_angle,
            {in_bus_sample, in_phase_c_sample, in_phase_b_sample, in_phase_a_sample}));
      end
    end
    pending    <= expected_estimates.size();
    mismatches <= errors;
  end

endmodule

>>> test/tb.sv
module tb;
  import encadc_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 200;
  localparam logic [ANGLE_BITS_DEF-1:0]  ANGLE_TOP  = '1;
  localparam logic [ANGLE_BITS_DEF-1:0]  HALF_ANGLE = ANGLE_BITS_DEF'(1 << (ANGLE_BITS_DEF - 1));
  localparam logic [SAMPLE_BITS_DEF-1:0] COUNT_TOP  = '1;

  typedef enum {FLOW, COIN, STARVE, TOGGLE} stall_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [ANGLE_BITS_DEF-1:0]         in_angle = '0;
  logic [SAMPLE_BITS_DEF-1:0]        in_phase_a_sample = '0;
  logic [SAMPLE_BITS_DEF-1:0]        in_phase_b_sample = '0;
  logic [SAMPLE_BITS_DEF-1:0]        in_phase_c_sample = '0;
  logic [SAMPLE_BITS_DEF-1:0]        in_bus_sample = '0;

  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [POS_BITS-1:0]        out_position;
  logic signed [TURNS_OUT_BITS-1:0]  out_turns;
  logic signed [VEL_BITS-1:0]        out_fast_velocity;
  logic signed [VEL_BITS-1:0]        out_slow_velocity;
  logic signed [AVG_BITS-1:0]        out_phase_a_average;
  logic signed [AVG_BITS-1:0]        out_phase_b_average;
  logic signed [AVG_BITS-1:0]        out_phase_c_average;
  logic [BUS_AVG_BITS-1:0]           out_bus_average;

  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [CFG_INDEX_BITS-1:0]         cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]          cfg_data = '0;

  int pending;
  int mismatches;
  int idle_cycles = 0;
  int burst_left = 0;
  int spin = 0;
  logic [ANGLE_BITS_DEF-1:0] rotor_angle = '0;
  stall_mode_t ready_mode = FLOW;
  int ready_run = 0;

  encoder_adc_state_estimator_core dut (.*);
  state_estimate_checker checker_i (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (ready_run == 0) begin
      ready_mode <= stall_mode_t'($urandom_range(0, 3));
      ready_run  <= $urandom_range(10, 150);
    end else begin
      ready_run <= ready_run - 1;
    end
    case (ready_mode)
      FLOW:    out_ready <= 1'b1;
      COIN:    out_ready <= 1'($urandom_range(0, 1));
      STARVE:  out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= ~out_ready;
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // leaves cfg_valid high so back-to-back writes need no drop in between
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input int fast, input int slow, input int pos_ofs,
                              input int a_ofs, input int b_ofs, input int c_ofs);
    write_reg(REG_FAST_GAIN, fast);
    write_reg(REG_SLOW_GAIN, slow);
    write_reg(REG_POS_OFFSET, pos_ofs);
    write_reg(REG_A_OFFSET, a_ofs);
    write_reg(REG_B_OFFSET, b_ofs);
    write_reg(REG_C_OFFSET, c_ofs);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_sample(input logic [ANGLE_BITS_DEF-1:0] angle,
                             input logic [SAMPLE_BITS_DEF-1:0] a, b, c, bus);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid          <= 1'b1;
    in_angle          <= angle;
    in_phase_a_sample <= a;
    in_phase_b_sample <= b;
    in_phase_c_sample <= c;
    in_bus_sample     <= bus;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold the sender until every queued estimate has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic int pick_gain();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return int'(GAIN_ONE);
      2:       return $urandom();
      default: return $urandom_range(0, int'(GAIN_ONE));
    endcase
  endfunction

  function automatic logic [SAMPLE_BITS_DEF-1:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return COUNT_TOP;
      default: return SAMPLE_BITS_DEF'($urandom());
    endcase
  endfunction

  // mostly smooth rotation; now and then a wild jump or a step at half a turn
  task automatic push_random_sample();
    logic [ANGLE_BITS_DEF-1:0] a;
    logic [SAMPLE_BITS_DEF-1:0] bus;
    case ($urandom_range(0, 15))
      0:       a = ANGLE_BITS_DEF'($urandom());
      1:       a = rotor_angle + HALF_ANGLE;
      2:       a = ANGLE_BITS_DEF'(rotor_angle + HALF_ANGLE
                                   + (($urandom_range(0, 1) != 0) ? 1 : -1));
      default: a = ANGLE_BITS_DEF'(int'(rotor_angle) + spin + $urandom_range(0, 64) - 32);
    endcase
    rotor_angle = a;
    bus = ($urandom_range(0, 5) == 0) ? '0 : pick_count();
    push_sample(a, pick_count(), pick_count(), pick_count(), bus);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    program_regs(int'(GAIN_ONE), 4096, 0, 4095, -4096, 0);
    @(posedge clk);
    // indexes past the register map must be ignored
    for (int i = REG_C_OFFSET + 1; i < (1 << CFG_INDEX_BITS); i++) begin
      write_reg(CFG_INDEX_BITS'(i), $urandom());
    end
    cfg_valid <= 1'b0;

    push_sample('0, '0, '0, '0, '0);
    push_sample(ANGLE_TOP, COUNT_TOP, COUNT_TOP, COUNT_TOP, COUNT_TOP);
    push_sample('0, COUNT_TOP, '0, COUNT_TOP, '0);
    push_sample(HALF_ANGLE, '0, COUNT_TOP, '0, COUNT_TOP);
    push_sample('0, 12'd1, 12'd2048, 12'd4094, 12'd1);
    push_sample(HALF_ANGLE + 1'b1, COUNT_TOP, COUNT_TOP, '0, COUNT_TOP);
    push_sample('0, '0, COUNT_TOP, COUNT_TOP, COUNT_TOP);
    for (int i = 0; i < 14; i++) begin
      push_sample(ANGLE_BITS_DEF'(i * 4000),
                  i[0] ? COUNT_TOP : '0, i[1] ? COUNT_TOP : '0, COUNT_TOP,
                  (i % 3 == 0) ? '0 : SAMPLE_BITS_DEF'(i * 300 + 1));
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0:       program_regs(0, int'(GAIN_ONE), -536870912, -4096, -4096, -4096);
        1:       program_regs(int'(GAIN_ONE), 32'h1FFFF, 536870911, 4095, 4095, 4095);
        default: program_regs(pick_gain(), pick_gain(), $urandom(), $urandom(),
                              $urandom(), $urandom());
      endcase
      spin = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16000) - 8000
                                         : $urandom_range(0, 6000) - 3000;
      for (int n = 0; n < PHASE_ITEMS; n++) push_random_sample();
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
